// ----- rtl/port_range_bind_acl_defines.svh -----
// Assertion macros shared by the bind ACL checker.
`ifndef PORT_RANGE_BIND_ACL_DEFINES_SVH
`define PORT_RANGE_BIND_ACL_DEFINES_SVH

// Same-cycle implication, sampled on aclk, switched off while in reset.
`define PRBACL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("port_range_bind_acl: assertion failed");

// Next-cycle implication, sampled on aclk, switched off while in reset.
`define PRBACL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("port_range_bind_acl: assertion failed");

`endif

// ----- rtl/prbacl_pkg.sv -----
// Package of types, constants and helpers for the port range bind ACL.
`timescale 1ns / 1ps
`default_nettype none

package prbacl_pkg;

    // Table geometry.
    localparam int RULE_SLOTS     = 64;
    localparam int DOMAIN_ID_BITS = 8;
    localparam int IDX_W          = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CNT_W          = $clog2(RULE_SLOTS + 1);

    // Fixed field widths on the ports.
    localparam int DOMAIN_IN_W = 8;
    localparam int PORT_W      = 16;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 8;
    localparam int RES_BITS    = 5;

    // Bit positions of the input fields in s_tdata.
    localparam int DOM_LSB     = 0;
    localparam int TRUST_BIT   = DOM_LSB + DOMAIN_IN_W;
    localparam int TCP_BIT     = TRUST_BIT + 1;
    localparam int PLOW_LSB    = TCP_BIT + 1;
    localparam int PHIGH_LSB   = PLOW_LSB + PORT_W;

    // Operation codes carried in s_tuser.
    localparam logic OP_CHECK = 1'b0;
    localparam logic OP_ADD   = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CHECK_EN = 2'd0;
    localparam logic [1:0] CFG_ENFORCE  = 2'd1;
    localparam logic [1:0] CFG_LEARN    = 2'd2;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_DENIED = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_RANGE  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic check_en;
        logic enforce;
        logic learn;
    } cfg_t;

    typedef struct packed {
        logic                   op;
        logic [DOMAIN_IN_W-1:0] domain_id;
        logic                   domain_trusted;
        logic                   is_tcp;
        logic [PORT_W-1:0]      port_low;
        logic [PORT_W-1:0]      port_high;
    } item_t;

    typedef struct packed {
        logic [DOMAIN_ID_BITS-1:0] domain;
        logic                      is_tcp;
        logic [PORT_W-1:0]         low;
        logic [PORT_W-1:0]         high;
    } rule_t;

    localparam int RULE_W = $bits(rule_t);

    typedef struct packed {
        logic    learned;
        logic    audit_granted;
        logic    audit_valid;
        status_t status;
    } res_t;

    // Keeps the low DOMAIN_ID_BITS of the domain id, zero filling above it.
    function automatic logic [DOMAIN_ID_BITS-1:0] reduce_domain(
        input logic [DOMAIN_IN_W-1:0] d
    );
        logic [DOMAIN_ID_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < DOMAIN_ID_BITS; i++) begin
            if (i < DOMAIN_IN_W) begin
                r[i] = d[i];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/port_range_bind_acl.sv -----
// Top level of the port range bind ACL: ports, configuration and output register.
//
// Usage:
// - Input channel s_*: s_tuser carries the operation (check a bind or add a
//   rule); s_tdata carries the domain, trust flag, protocol and port range.
// - Result channel m_*: one transaction per input transaction, carrying the
//   status and the audit and learning flags.
// - Configuration: cfg_we writes register cfg_addr (0 check enable,
//   1 enforce mode, 2 learning mode) with cfg_wdata at the clock edge.
// - An item settled without the table (bad range, checking off, trusted
//   domain) goes from idle straight to the done state; any other item passes
//   through the scan and decide states first. The scan reads one stored rule
//   per cycle through one RAM read port and a single compare unit. m_tvalid
//   rises once the result is in the output register.
// - s_tready is low from acceptance until the result is handed to the output
//   register, so one item is in flight at a time.
// - The output register frees the sequencer while a result waits; if the
//   receiver stalls, the next item is still accepted and its result waits.
// - Reset clears the rule count, the configuration registers and both
//   handshakes; table contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module port_range_bind_acl (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // s_tdata fields from bit 0: domain_id[7:0], domain_trusted, is_tcp,
    // port_low[15:0], port_high[15:0], zero padding
    input  wire logic [prbacl_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser fields from bit 0: op
    input  wire logic                                s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // m_tdata fields from bit 0: status[1:0], audit_valid, audit_granted,
    // learned, zero padding
    output logic      [prbacl_pkg::M_TDATA_W-1:0]    m_tdata,
    input  wire logic                                cfg_we,
    input  wire logic [1:0]                          cfg_addr,
    input  wire logic                                cfg_wdata
);
    import prbacl_pkg::*;

    cfg_t                 cfg_reg, cfg_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    item_t                item;
    res_t                 res;
    logic                 res_valid;
    logic                 res_ready;

    // Unpack the input transaction.
    always_comb begin
        item.op             = s_tuser;
        item.domain_id      = s_tdata[DOM_LSB +: DOMAIN_IN_W];
        item.domain_trusted = s_tdata[TRUST_BIT];
        item.is_tcp         = s_tdata[TCP_BIT];
        item.port_low       = s_tdata[PLOW_LSB +: PORT_W];
        item.port_high      = s_tdata[PHIGH_LSB +: PORT_W];
    end

    // Configuration register writes; an unknown index is ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_CHECK_EN: cfg_next.check_en = cfg_wdata;
                CFG_ENFORCE:  cfg_next.enforce  = cfg_wdata;
                CFG_LEARN:    cfg_next.learn    = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    prbacl_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .item      (item),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: takes a new result whenever it is empty or being drained.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{(M_TDATA_W - RES_BITS){1'b0}}, res};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cfg_reg      <= cfg_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ----- rtl/prbacl_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module prbacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/prbacl_cmp.sv -----
// Rule compare unit: tests whether one stored rule covers the search key.
`timescale 1ns / 1ps
`default_nettype none

module prbacl_cmp (
    input  wire prbacl_pkg::rule_t entry,
    input  wire prbacl_pkg::rule_t key,
    output logic                   hit
);
    import prbacl_pkg::*;

    logic same_owner;
    logic range_in;

    // Same domain and protocol, and the key range lies inside the rule range.
    assign same_owner = (entry.domain == key.domain) && (entry.is_tcp == key.is_tcp);
    assign range_in   = (entry.low <= key.low) && (key.high <= entry.high);
    assign hit        = same_owner && range_in;

endmodule

`default_nettype wire

// ----- rtl/prbacl_ctrl.sv -----
// Sequencer: scans the rule table through the compare unit, then decides and inserts.
`timescale 1ns / 1ps
`default_nettype none

module prbacl_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire prbacl_pkg::item_t item,
    input  wire prbacl_pkg::cfg_t  cfg,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output prbacl_pkg::res_t       res
);
    import prbacl_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pend_reg, pend_next;
    logic             hit_reg, hit_next;
    logic             op_reg, op_next;
    rule_t            key_reg, key_next;
    res_t             res_reg, res_next;

    rule_t            in_key;
    rule_t            entry;
    logic [RULE_W-1:0] ram_rdata;
    logic             ram_we;
    logic             hit_now;
    logic             early_range;
    logic             early_off;
    logic             early_trust;
    logic             early;
    logic             scan_more;
    logic             table_full;

    // Rule storage, read one entry per cycle during the scan.
    prbacl_ram #(
        .WIDTH (RULE_W),
        .DEPTH (RULE_SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (key_reg),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign entry = rule_t'(ram_rdata);

    // The one compare unit, reused for every stored rule.
    prbacl_cmp u_cmp (
        .entry (entry),
        .key   (key_reg),
        .hit   (hit_now)
    );

    // Search key of the incoming item; a check searches a single-port range.
    always_comb begin
        in_key.domain = reduce_domain(item.domain_id);
        in_key.is_tcp = item.is_tcp;
        in_key.low    = item.port_low;
        in_key.high   = (item.op == OP_ADD) ? item.port_high : item.port_low;
    end

    // Items that are settled without touching the table.
    assign early_range = (item.op == OP_ADD) && (item.port_low > item.port_high);
    assign early_off   = (item.op == OP_CHECK) && !cfg.check_en;
    assign early_trust = (item.op == OP_CHECK) && cfg.check_en && item.domain_trusted;
    assign early       = early_range || early_off || early_trust;

    assign scan_more  = (idx_reg < count_reg);
    assign table_full = (count_reg == CNT_W'(RULE_SLOTS));

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = early ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!scan_more && !pend_reg) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath updates and table writes per state.
    always_comb begin
        idx_next   = idx_reg;
        count_next = count_reg;
        pend_next  = pend_reg;
        hit_next   = hit_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    key_next               = in_key;
                    op_next                = item.op;
                    idx_next               = '0;
                    pend_next              = 1'b0;
                    hit_next               = 1'b0;
                    res_next.status        = early_range ? STAT_RANGE : STAT_OK;
                    res_next.audit_valid   = early_trust;
                    res_next.audit_granted = early_trust;
                    res_next.learned       = 1'b0;
                end
            end
            ST_SCAN: begin
                // Read data is registered, so it arrives in the cycle after its address.
                pend_next = scan_more;
                if (scan_more) begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                if (pend_reg && hit_now) begin
                    hit_next = 1'b1;
                end
            end
            ST_DECIDE: begin
                res_next.learned = 1'b0;
                if (op_reg == OP_ADD) begin
                    res_next.audit_valid   = 1'b0;
                    res_next.audit_granted = 1'b0;
                    if (hit_reg) begin
                        res_next.status = STAT_OK;
                    end else if (table_full) begin
                        res_next.status = STAT_FULL;
                    end else begin
                        res_next.status = STAT_OK;
                        ram_we          = 1'b1;
                        count_next      = count_reg + CNT_W'(1);
                    end
                end else begin
                    res_next.audit_valid   = 1'b1;
                    res_next.audit_granted = hit_reg;
                    if (!hit_reg && cfg.enforce) begin
                        res_next.status = STAT_DENIED;
                    end else begin
                        res_next.status = STAT_OK;
                    end
                    // Learning inserts the port as a rule; a full table skips it.
                    if (!hit_reg && !cfg.enforce && cfg.learn && !table_full) begin
                        ram_we           = 1'b1;
                        count_next       = count_reg + CNT_W'(1);
                        res_next.learned = 1'b1;
                    end
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers are reset; payload registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
        idx_reg <= idx_next;
        hit_reg <= hit_next;
        op_reg  <= op_next;
        key_reg <= key_next;
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

// ----- rtl/prbacl_checker.sv -----
// Port-level checker for the port range bind ACL, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "port_range_bind_acl_defines.svh"

module prbacl_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [prbacl_pkg::M_TDATA_W-1:0] m_tdata
);
    import prbacl_pkg::*;

    // A stalled result transaction holds its value.
    `PRBACL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // The block works on one item at a time: busy right after an acceptance.
    `PRBACL_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // A granted audit is always a valid audit.
    `PRBACL_ASSERT_NOW(a_grant_needs_audit, m_tvalid && m_tdata[3], m_tdata[2])

    // A learned rule comes only from an audited, ungranted and allowed check.
    `PRBACL_ASSERT_NOW(a_learn_shape, m_tvalid && m_tdata[4],
        m_tdata[2] && !m_tdata[3] && (m_tdata[1:0] == STAT_OK))

endmodule

bind port_range_bind_acl prbacl_checker u_prbacl_checker (.*);

`default_nettype wire

// ----- dv/port_range_bind_acl_check.sv -----
// Checker for the port range bind ACL: tracks the rule table and compares every result.
`timescale 1ns / 1ps

module port_range_bind_acl_check
    import prbacl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_addr,
    input  logic                 cfg_wdata,
    output int                   fail_count,
    output int                   verdicts_open
);

    // Shadow copy of the rule store and the mode registers.
    rule_t rules [RULE_SLOTS];
    int    rules_held;
    logic  check_on;
    logic  enforce_on;
    logic  learn_on;

    // Verdicts predicted for accepted requests, oldest first.
    res_t  verdicts_due [$];

    // One line per mismatch, and the count handed to the top.
    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("%0t ns: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
        fail_count++;
    endtask

    // True when a held rule for this domain and protocol spans [lo, hi].
    function automatic logic span_covered(input logic [DOMAIN_ID_BITS-1:0] dom,
                                          input logic tcp, input logic [PORT_W-1:0] lo,
                                          input logic [PORT_W-1:0] hi);
        for (int i = 0; i < rules_held; i++) begin
            if (rules[i].domain == dom && rules[i].is_tcp == tcp &&
                rules[i].low <= lo && hi <= rules[i].high) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Stores a rule unless it is already covered; a full store reports STAT_FULL.
    function automatic status_t store_rule(input logic [DOMAIN_ID_BITS-1:0] dom,
                                           input logic tcp, input logic [PORT_W-1:0] lo,
                                           input logic [PORT_W-1:0] hi, output logic added);
        added = 1'b0;
        if (span_covered(dom, tcp, lo, hi)) begin
            return STAT_OK;
        end
        if (rules_held >= RULE_SLOTS) begin
            return STAT_FULL;
        end
        rules[rules_held].domain = dom;
        rules[rules_held].is_tcp = tcp;
        rules[rules_held].low    = lo;
        rules[rules_held].high   = hi;
        rules_held++;
        added = 1'b1;
        return STAT_OK;
    endfunction

    // Works out the verdict of one request and applies its effect on the store.
    function automatic res_t judge_request(input logic op, input logic [DOMAIN_IN_W-1:0] dom_in,
                                           input logic trusted, input logic tcp,
                                           input logic [PORT_W-1:0] lo,
                                           input logic [PORT_W-1:0] hi);
        res_t                      v;
        logic [DOMAIN_ID_BITS-1:0] dom;
        logic                      added;
        v      = '0;
        v.status = STAT_OK;
        dom    = reduce_domain(dom_in);
        added  = 1'b0;
        if (op == OP_ADD) begin
            if (lo > hi) begin
                v.status = STAT_RANGE;
            end else begin
                v.status = store_rule(dom, tcp, lo, hi, added);
            end
        end else if (check_on) begin
            v.audit_valid = 1'b1;
            if (trusted || span_covered(dom, tcp, lo, lo)) begin
                v.audit_granted = 1'b1;
            end else if (enforce_on) begin
                v.status = STAT_DENIED;
            end else if (learn_on) begin
                // A full store silently skips the learnt rule.
                void'(store_rule(dom, tcp, lo, lo, added));
                v.learned = added;
            end
        end
        return v;
    endfunction

    // Watch both channels and the register port at every rising edge.
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (!aresetn) begin
            rules_held = 0;
            check_on   = 1'b0;
            enforce_on = 1'b0;
            learn_on   = 1'b0;
            verdicts_due.delete();
        end else begin
            // Result transaction against the oldest prediction.
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata[RES_BITS-1:0]);
                if (verdicts_due.size() == 0) begin
                    report_mismatch("result with nothing expected", 8'h00, m_tdata);
                end else begin
                    want = verdicts_due.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", 8'(want.status), 8'(got.status));
                    if (got.audit_valid !== want.audit_valid)
                        report_mismatch("audit_valid", 8'(want.audit_valid),
                                        8'(got.audit_valid));
                    if (got.audit_granted !== want.audit_granted)
                        report_mismatch("audit_granted", 8'(want.audit_granted),
                                        8'(got.audit_granted));
                    if (got.learned !== want.learned)
                        report_mismatch("learned", 8'(want.learned), 8'(got.learned));
                    if (m_tdata[M_TDATA_W-1:RES_BITS] !== '0)
                        report_mismatch("padding", 8'h00,
                                        8'(m_tdata[M_TDATA_W-1:RES_BITS]));
                end
            end
            // Request transaction: predict its verdict now, in acceptance order.
            if (s_tvalid && s_tready) begin
                verdicts_due.push_back(judge_request(s_tuser,
                    s_tdata[DOM_LSB +: DOMAIN_IN_W], s_tdata[TRUST_BIT], s_tdata[TCP_BIT],
                    s_tdata[PLOW_LSB +: PORT_W], s_tdata[PHIGH_LSB +: PORT_W]));
            end
            // Register writes; an unknown index changes nothing.
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_CHECK_EN: check_on = cfg_wdata;
                    CFG_ENFORCE: enforce_on = cfg_wdata;
                    CFG_LEARN: learn_on = cfg_wdata;
                    default: ;
                endcase
            end
        end
        verdicts_open = verdicts_due.size();
    end

endmodule

// ----- dv/port_range_bind_acl_test.sv -----
// Testbench top for the port range bind ACL: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module port_range_bind_acl_test;
    import prbacl_pkg::*;

    // Register index that maps to no register.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we;
    logic [1:0]           cfg_addr;
    logic                 cfg_wdata;
    int                   fail_count;
    int                   verdicts_open;

    // When set, neither side inserts idle cycles.
    logic                 quiet;
    // Recently added rule spans, used to aim requests at stored rules.
    item_t                known [$];

    port_range_bind_acl dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    port_range_bind_acl_check checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .verdicts_open (verdicts_open)
    );

    // 100 MHz clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #15_000_000;
        $display("port_range_bind_acl_test: done, errors");
        $finish;
    end

    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic item_t make_req(input logic op, input logic [7:0] dom,
                                       input logic trusted, input logic tcp,
                                       input logic [15:0] lo, input logic [15:0] hi);
        item_t it;
        it.op             = op;
        it.domain_id      = dom;
        it.domain_trusted = trusted;
        it.is_tcp         = tcp;
        it.port_low       = lo;
        it.port_high      = hi;
        return it;
    endfunction

    // Mostly a handful of domains so that rules get hit, sometimes any id.
    function automatic logic [7:0] pick_domain();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return 8'($urandom_range(0, 3));
        if (r == 7) return 8'hff;
        return 8'($urandom_range(0, 255));
    endfunction

    // Random request: adds of varied shape, checks aimed at stored rules, and noise.
    function automatic item_t random_item();
        item_t it;
        int    r;
        int    k;
        int    lo;
        int    hi;
        it = make_req(OP_CHECK, pick_domain(), $urandom_range(0, 9) == 0,
                      1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
        r  = $urandom_range(0, 99);
        if (r < 12) begin
            it.op = OP_ADD;
            if (r < 2) begin
                // Inverted range.
                lo = $urandom_range(1, 65535);
                hi = $urandom_range(0, lo - 1);
            end else if (r < 5 && known.size() > 0) begin
                // Sub-range of a rule already added.
                k            = $urandom_range(0, known.size() - 1);
                it.domain_id = known[k].domain_id;
                it.is_tcp    = known[k].is_tcp;
                lo           = $urandom_range(known[k].port_low, known[k].port_high);
                hi           = $urandom_range(lo, known[k].port_high);
            end else if (r == 5) begin
                lo = 0;
                hi = 65535;
            end else begin
                lo = $urandom_range(0, 65535);
                hi = lo + $urandom_range(0, 300);
                if (hi > 65535) hi = 65535;
            end
            it.port_low  = 16'(lo);
            it.port_high = 16'(hi);
            if (lo <= hi) begin
                known.push_back(it);
                if (known.size() > 32) void'(known.pop_front());
            end
        end else if (r < 70 && known.size() > 0) begin
            // Check inside a stored span, or just past its top.
            k            = $urandom_range(0, known.size() - 1);
            it.domain_id = known[k].domain_id;
            it.is_tcp    = known[k].is_tcp;
            if ($urandom_range(0, 4) == 0)
                it.port_low = known[k].port_high + 16'd1;
            else
                it.port_low = 16'($urandom_range(known[k].port_low, known[k].port_high));
        end
        return it;
    endfunction

    // Presents one request after a random gap and returns once it is accepted.
    task automatic send_request(input item_t it);
        int                   gap;
        logic [S_TDATA_W-1:0] word;
        gap  = draw_wait();
        word = '0;
        word[DOM_LSB +: DOMAIN_IN_W] = it.domain_id;
        word[TRUST_BIT]              = it.domain_trusted;
        word[TCP_BIT]                = it.is_tcp;
        word[PLOW_LSB +: PORT_W]     = it.port_low;
        word[PHIGH_LSB +: PORT_W]    = it.port_high;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= it.op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drops the request valid and waits for every outstanding verdict.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (verdicts_open != 0) @(negedge aclk);
    endtask

    // Writes the three mode registers, with a write to the unused index first.
    task automatic program_modes(input logic ce, input logic en, input logic ln);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_UNUSED;
        cfg_wdata <= 1'($urandom_range(0, 1));
        @(negedge aclk);
        cfg_addr  <= CFG_CHECK_EN;
        cfg_wdata <= ce;
        @(negedge aclk);
        cfg_addr  <= CFG_ENFORCE;
        cfg_wdata <= en;
        @(negedge aclk);
        cfg_addr  <= CFG_LEARN;
        cfg_wdata <= ln;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Result side: random stall before each transaction.
    initial begin
        int stall;
        m_tready = 1'b0;
        forever begin
            stall = draw_wait();
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Request side and verdict.
    initial begin
        logic [2:0] modes;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_CHECK;
        cfg_we    = 1'b0;
        cfg_addr  = CFG_CHECK_EN;
        cfg_wdata = 1'b0;
        quiet     = 1'b0;
        aresetn   = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Registers at reset: checking off, then the add cases.
        send_request(make_req(OP_CHECK, 8'd1, 1'b0, 1'b1, 16'd80, 16'hffff));
        send_request(make_req(OP_ADD, 8'd1, 1'b0, 1'b1, 16'hffff, 16'd0));
        send_request(make_req(OP_ADD, 8'd1, 1'b1, 1'b1, 16'd100, 16'd200));
        send_request(make_req(OP_ADD, 8'd1, 1'b0, 1'b1, 16'd120, 16'd150));
        send_request(make_req(OP_ADD, 8'd1, 1'b0, 1'b0, 16'd100, 16'd200));
        send_request(make_req(OP_ADD, 8'hff, 1'b0, 1'b1, 16'hffff, 16'hffff));
        send_request(make_req(OP_ADD, 8'd0, 1'b0, 1'b0, 16'd0, 16'd0));
        settle();

        // Enforcing: match, miss, trusted, match under the other protocol, extremes, unknown domain.
        program_modes(1'b1, 1'b1, 1'b0);
        send_request(make_req(OP_CHECK, 8'd1, 1'b0, 1'b1, 16'd150, 16'd0));
        send_request(make_req(OP_CHECK, 8'd1, 1'b0, 1'b1, 16'd201, 16'd0));
        send_request(make_req(OP_CHECK, 8'd1, 1'b1, 1'b1, 16'd99, 16'd0));
        send_request(make_req(OP_CHECK, 8'd1, 1'b0, 1'b0, 16'd150, 16'd0));
        send_request(make_req(OP_CHECK, 8'hff, 1'b0, 1'b1, 16'hffff, 16'hffff));
        send_request(make_req(OP_CHECK, 8'd0, 1'b0, 1'b0, 16'd0, 16'd0));
        send_request(make_req(OP_CHECK, 8'd2, 1'b0, 1'b1, 16'd150, 16'd0));
        settle();

        // Learning: first miss learns, repeat matches, trusted learns nothing.
        program_modes(1'b1, 1'b0, 1'b1);
        send_request(make_req(OP_CHECK, 8'd3, 1'b0, 1'b0, 16'd7, 16'd0));
        send_request(make_req(OP_CHECK, 8'd3, 1'b0, 1'b0, 16'd7, 16'd0));
        send_request(make_req(OP_CHECK, 8'd4, 1'b1, 1'b1, 16'd9, 16'd0));
        settle();

        // Audit only: a miss is audited as not granted but still allowed.
        program_modes(1'b1, 1'b0, 1'b0);
        send_request(make_req(OP_CHECK, 8'd5, 1'b0, 1'b1, 16'd11, 16'd0));
        settle();

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: modes = 3'b100;
                1: modes = 3'b101;
                2: modes = 3'b111;
                3: modes = 3'b011;
                default: modes = 3'($urandom_range(0, 7));
            endcase
            program_modes(modes[2], modes[1], modes[0]);
            for (int n = 0; n < 250; n++) begin
                if (n % 50 == 0) quiet = ($urandom_range(0, 4) == 0);
                send_request(random_item());
            end
            settle();
        end

        quiet = 1'b0;
        repeat (80) @(negedge aclk);
        if (fail_count == 0) begin
            $display("port_range_bind_acl_test: done, clean");
        end else begin
            $display("port_range_bind_acl_test: done, errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/prbacl_pkg.sv
rtl/prbacl_ram.sv
rtl/prbacl_cmp.sv
rtl/prbacl_ctrl.sv
rtl/port_range_bind_acl.sv
rtl/prbacl_checker.sv
dv/port_range_bind_acl_check.sv
dv/port_range_bind_acl_test.sv
